[src/mnct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mnct_pkg
// Types and constants shared by the MIDI NRPN control translator.
// ---------------------------------------------------------------------------
package mnct_pkg;

  localparam int CTRL_W = 12;

  // configuration register indexes
  localparam logic [1:0] CFG_CLOSE_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_FINE_STEP       = 2'd1;
  localparam logic [1:0] CFG_COARSE_STEP     = 2'd2;
  localparam logic [1:0] CFG_KNOB_CHANNEL    = 2'd3;

  localparam logic [13:0] THRESHOLD_RST = 14'd400;
  localparam logic [6:0]  FINE_RST      = 7'd1;
  localparam logic [6:0]  COARSE_RST    = 7'd5;
  localparam logic [3:0]  CHANNEL_RST   = 4'd0;

  localparam logic [7:0] ST_CC16    = 8'hBF;
  localparam logic [7:0] ST_CC_BASE = 8'hB0;
  localparam logic [7:0] CC_NRPN_MSB = 8'h63;
  localparam logic [7:0] CC_NRPN_LSB = 8'h62;
  localparam logic [7:0] CC_DATA_MSB = 8'h06;
  localparam logic [7:0] CC_DATA_LSB = 8'h26;

  localparam logic [6:0] NH_KNOB    = 7'h03;
  localparam logic [6:0] NH_KNOB_HI = 7'h0B;
  localparam logic [6:0] NH_BUTTON  = 7'h13;
  localparam logic [6:0] NH_FADER   = 7'h1B;
  localparam logic [6:0] NH_GROUP   = 7'h23;

  localparam logic [6:0] NL_MASTER   = 7'h17;
  localparam logic [6:0] NL_FADER0   = 7'h2C;
  localparam logic [6:0] NL_KNOB0    = 7'h74;
  localparam logic [6:0] NL_KNOB_HI0 = 7'h5C;
  localparam logic [6:0] NL_BUTTON0  = 7'h44;
  localparam logic [6:0] NL_GROUP0   = 7'h14;

  localparam logic signed [14:0] FADER_RST = -15'sd5000;

  typedef struct packed {
    logic [13:0] thr;
    logic [6:0]  fine;
    logic [6:0]  coarse;
    logic [3:0]  chan;
  } mnct_cfg_t;

  typedef struct packed {
    logic       from_surface;
    logic [7:0] status;
    logic [7:0] first;
    logic [7:0] second;
  } mnct_item_t;

  typedef struct packed {
    logic       to_sw;
    logic [7:0] status;
    logic [7:0] first;
    logic [7:0] second;
  } mnct_word_t;

  typedef struct packed {
    mnct_word_t [3:0] w;
    logic [2:0]       n;
  } mnct_res_t;

  function automatic logic signed [CTRL_W-1:0] sx7(input logic [6:0] x);
    return signed'({{(CTRL_W-7){1'b0}}, x});
  endfunction

endpackage
`default_nettype wire

[src/midi_nrpn_control_translator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// midi_nrpn_control_translator
// NRPN translation between a control surface and software, top level.
// ---------------------------------------------------------------------------
// A message word is taken into an input register and decoded from it
// against the stored NRPN, fader, knob and button state once the result
// register can take its output words (none, one or four); these land in a
// result register that sends one word per cycle while out_tready is high.
// A new input word is taken as soon as the result register is free or
// sending its final word.
module midi_nrpn_control_translator import mnct_pkg::*; #(
  parameter int NUM_FADERS = 9,
  parameter int NUM_KNOBS  = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // status_byte, first_data, second_data
  input  logic        in_tuser,   // from_surface
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_status, out_first, out_second
  output logic        out_tuser,  // to_software
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_wdata
);

  mnct_cfg_t  cfg_r;
  mnct_item_t item_r;
  logic       in_vld_r;
  mnct_res_t  res;
  logic       take, fire;

  assign fire      = in_vld_r && take;
  assign in_tready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr    <= THRESHOLD_RST;
      cfg_r.fine   <= FINE_RST;
      cfg_r.coarse <= COARSE_RST;
      cfg_r.chan   <= CHANNEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLOSE_THRESHOLD: cfg_r.thr    <= cfg_wdata;
        CFG_FINE_STEP:       cfg_r.fine   <= cfg_wdata[6:0];
        CFG_COARSE_STEP:     cfg_r.coarse <= cfg_wdata[6:0];
        CFG_KNOB_CHANNEL:    cfg_r.chan   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.from_surface <= in_tuser;
      item_r.status       <= in_tdata[7:0];
      item_r.first        <= in_tdata[15:8];
      item_r.second       <= in_tdata[23:16];
    end
  end

  mnct_digest #(
    .NUM_FADERS (NUM_FADERS),
    .NUM_KNOBS  (NUM_KNOBS)
  ) u_digest (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  mnct_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && (res.n != 3'd0)),
    .res        (res),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

[src/mnct_digest.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mnct_digest
// NRPN collection state, fader/knob/button stores and the per-word decode.
// ---------------------------------------------------------------------------
module mnct_digest import mnct_pkg::*; #(
  parameter int NUM_FADERS = 9,
  parameter int NUM_KNOBS  = 18
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       upd,
  input  mnct_item_t item,
  input  mnct_cfg_t  cfg,
  output mnct_res_t  res
);

  localparam int FIW = (NUM_FADERS > 1) ? $clog2(NUM_FADERS) : 1;
  localparam int KIW = $clog2(NUM_KNOBS);
  localparam logic signed [CTRL_W-1:0] NF_S  = CTRL_W'(NUM_FADERS);
  localparam logic signed [CTRL_W-1:0] NK_S  = CTRL_W'(NUM_KNOBS);
  localparam logic signed [CTRL_W-1:0] NF_M1 = CTRL_W'(NUM_FADERS - 1);

  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_PASS  = 3'd1;
  localparam logic [2:0] K_FWD   = 3'd2;
  localparam logic [2:0] K_FADER = 3'd3;
  localparam logic [2:0] K_CTRL  = 3'd4;

  logic [6:0]        nh_r [2];
  logic [6:0]        nl_r [2];
  logic [6:0]        eh_r [2];
  logic signed [14:0] fl_r [NUM_FADERS];
  logic [6:0]        kl_r [NUM_KNOBS];
  logic              fm_r [NUM_FADERS];

  logic                     d;
  logic [6:0]               v7, nh, nl, eh;
  logic                     is16, down;
  logic [2:0]               kind;
  logic signed [CTRL_W-1:0] fidx, ctrl, bt, kb;
  logic                     f_ok, f_pass;
  logic [FIW-1:0]           fi;
  logic signed [14:0]       last;
  logic signed [15:0]       diff;
  logic [15:0]              adiff;
  logic                     c_ok, is_btn, bt_ok, is_knob, kb_ok, fine;
  logic [6:0]               lvl_cur, step, lvl_new;
  logic [7:0]               sum8;

  assign d    = item.from_surface;
  assign v7   = item.second[6:0];
  assign nh   = nh_r[d];
  assign nl   = nl_r[d];
  assign eh   = eh_r[d];
  assign is16 = (item.status == ST_CC16);
  assign down = (eh != 7'd0);

  always_comb begin
    kind = K_NONE;
    fidx = '0;
    ctrl = '0;
    if (!is16) begin
      kind = K_PASS;
    end else if (item.first == CC_DATA_LSB) begin
      if (!d) begin
        if (nh == NH_GROUP && nl == NL_MASTER) begin
          kind = K_FADER;
          fidx = NF_M1;
        end else if (nh == NH_FADER) begin
          kind = K_FADER;
          fidx = sx7(nl) - sx7(NL_FADER0);
        end else begin
          kind = K_FWD;
        end
      end else begin
        case (nh)
          NH_KNOB: begin
            kind = K_CTRL;
            ctrl = sx7(nl) - sx7(NL_KNOB0);
          end
          NH_KNOB_HI: begin
            kind = K_CTRL;
            ctrl = NF_S + sx7(nl) - sx7(NL_KNOB_HI0);
          end
          NH_BUTTON: begin
            kind = K_CTRL;
            ctrl = NK_S + sx7(nl) - sx7(NL_BUTTON0);
          end
          NH_GROUP: begin
            if (nl >= NL_MASTER) begin
              kind = K_FADER;
              fidx = NF_M1;
            end else begin
              kind = K_CTRL;
              ctrl = (sx7(nl) - sx7(NL_GROUP0)) * NF_S + NF_M1;
            end
          end
          NH_FADER: begin
            kind = K_FADER;
            fidx = sx7(nl) - sx7(NL_FADER0);
          end
          default: kind = K_FWD;
        endcase
      end
    end
  end

  // fader closeness check
  assign f_ok   = !fidx[CTRL_W-1] && (fidx < NF_S);
  assign fi     = fidx[FIW-1:0];
  assign last   = f_ok ? fl_r[fi] : 15'sd0;
  assign diff   = {last[14], last} - signed'({2'b00, eh, v7});
  assign adiff  = diff[15] ? 16'(-diff) : 16'(diff);
  assign f_pass = f_ok && (adiff >= {2'b00, cfg.thr});

  // knobs and buttons
  assign c_ok    = !ctrl[CTRL_W-1];
  assign is_btn  = c_ok && (ctrl >= NK_S);
  assign bt      = ctrl - NK_S;
  assign bt_ok   = is_btn && (bt < NF_S);
  assign is_knob = c_ok && (ctrl < NK_S);
  assign kb      = (ctrl >= NF_S) ? (ctrl - NF_S) : ctrl;
  assign kb_ok   = is_knob && (kb < NF_S);
  assign fine    = kb_ok ? fm_r[kb[FIW-1:0]] : 1'b0;
  assign lvl_cur = is_knob ? kl_r[ctrl[KIW-1:0]] : 7'd0;
  assign step    = fine ? cfg.fine : cfg.coarse;
  assign sum8    = {1'b0, lvl_cur} + {1'b0, step};

  always_comb begin
    if (down) begin
      lvl_new = (step > lvl_cur) ? 7'd0 : (lvl_cur - step);
    end else begin
      lvl_new = sum8[7] ? 7'd127 : sum8[6:0];
    end
  end

  always_comb begin
    res = '0;
    if (kind == K_PASS) begin
      res.w[0] = '{to_sw: d, status: item.status, first: item.first, second: item.second};
      res.n    = 3'd1;
    end else if (kind == K_FWD || (kind == K_FADER && f_pass)) begin
      res.w[0] = '{to_sw: d, status: ST_CC16, first: CC_NRPN_MSB, second: {1'b0, nh}};
      res.w[1] = '{to_sw: d, status: ST_CC16, first: CC_NRPN_LSB, second: {1'b0, nl}};
      res.w[2] = '{to_sw: d, status: ST_CC16, first: CC_DATA_MSB, second: {1'b0, eh}};
      res.w[3] = '{to_sw: d, status: ST_CC16, first: CC_DATA_LSB, second: {1'b0, v7}};
      res.n    = 3'd4;
    end else if (kind == K_CTRL && is_knob) begin
      res.w[0] = '{to_sw: 1'b1, status: ST_CC_BASE | {4'd0, cfg.chan},
                   first: ctrl[7:0] + 8'd1, second: {1'b0, lvl_new}};
      res.n    = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        nh_r[i] <= '0;
        nl_r[i] <= '0;
        eh_r[i] <= '0;
      end
      for (int i = 0; i < NUM_FADERS; i++) begin
        fl_r[i] <= FADER_RST;
        fm_r[i] <= 1'b0;
      end
      for (int i = 0; i < NUM_KNOBS; i++) begin
        kl_r[i] <= '0;
      end
    end else if (upd) begin
      if (is16) begin
        case (item.first)
          CC_NRPN_MSB: nh_r[d] <= v7;
          CC_NRPN_LSB: nl_r[d] <= v7;
          CC_DATA_MSB: eh_r[d] <= v7;
          default: ;
        endcase
      end
      if (kind == K_FADER && f_pass) begin
        fl_r[fi] <= signed'({1'b0, eh, v7});
      end
      if (kind == K_CTRL && bt_ok) begin
        fm_r[bt[FIW-1:0]] <= !down;
      end
      if (kind == K_CTRL && is_knob) begin
        kl_r[ctrl[KIW-1:0]] <= lvl_new;
      end
    end
  end

endmodule
`default_nettype wire

[src/mnct_obuf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mnct_obuf
// Result register holding up to four words, sent out one word per cycle while out_tready is high.
// ---------------------------------------------------------------------------
module mnct_obuf import mnct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  mnct_res_t   res,
  output logic        take,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // status, first, second
  output logic        out_tuser,  // to_software
  output logic        out_tlast   // last_of_run
);

  mnct_word_t [3:0] wbuf_r;
  logic [1:0]       cnt_r, idx_r, idx_nxt;
  logic             vld_r, vld_nxt;
  logic             last;
  mnct_word_t       w;

  assign w          = wbuf_r[idx_r];
  assign last       = (idx_r == cnt_r);
  assign out_tvalid = vld_r;
  assign out_tdata  = {w.second, w.first, w.status};
  assign out_tuser  = w.to_sw;
  assign out_tlast  = last;
  assign take       = !vld_r || (out_tready && last);

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = 2'd0;
    end else if (vld_r && out_tready) begin
      if (last) begin
        vld_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wbuf_r <= res.w;
      cnt_r  <= 2'(res.n - 3'd1);
    end
  end

endmodule
`default_nettype wire

[verif/nrpn_translation_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nrpn_translation_checker
// Watches the message, result and register ports of the NRPN translator.
// Each accepted message word is run through a local model of the NRPN
// collection, fader, knob and button state. The model queues the words it
// expects. Each word leaving the block is compared field by field with the
// oldest queued word.
// ---------------------------------------------------------------------------
module nrpn_translation_checker import mnct_pkg::*; #(
  parameter int NUM_FADERS = 9,
  parameter int NUM_KNOBS  = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // status_byte, first_data, second_data
  input  logic        in_tuser,   // from_surface
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // out_status, out_first, out_second
  input  logic        out_tuser,  // to_software
  input  logic        out_tlast,  // last_of_run
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_wdata,
  output int          mismatches,
  output int          waiting
);

  typedef struct packed {
    logic       to_sw;
    logic [7:0] status;
    logic [7:0] first;
    logic [7:0] second;
    logic       last;
  } midi_msg_t;

  logic [13:0] thr;
  logic [6:0]  fine_st;
  logic [6:0]  coarse_st;
  logic [3:0]  knob_chan;

  logic [6:0] num_hi [2];
  logic [6:0] num_lo [2];
  logic [6:0] ent_hi [2];
  logic [6:0] ent_lo [2];
  int         fader_pos [NUM_FADERS];
  logic [6:0] knob_lvl [NUM_KNOBS];
  logic       fine_sel [NUM_FADERS];

  midi_msg_t pending_msgs[$];
  midi_msg_t run_msgs[$];
  int        bad_count = 0;

  task automatic put(input logic dst, input logic [7:0] st, a, b);
    midi_msg_t m;
    m.to_sw  = dst;
    m.status = st;
    m.first  = a;
    m.second = b;
    m.last   = 1'b0;
    run_msgs.push_back(m);
  endtask

  task automatic relay_nrpn(input int d);
    put(d[0], ST_CC16, CC_NRPN_MSB, {1'b0, num_hi[d]});
    put(d[0], ST_CC16, CC_NRPN_LSB, {1'b0, num_lo[d]});
    put(d[0], ST_CC16, CC_DATA_MSB, {1'b0, ent_hi[d]});
    put(d[0], ST_CC16, CC_DATA_LSB, {1'b0, ent_lo[d]});
  endtask

  task automatic move_fader(input int d, input int idx);
    int v;
    int delta;
    if (idx < 0 || idx >= NUM_FADERS) return;
    v = int'(ent_hi[d]) * 128 + int'(ent_lo[d]);
    delta = fader_pos[idx] - v;
    if (delta < 0) delta = -delta;
    if (delta < int'(thr)) return;
    fader_pos[idx] = v;
    relay_nrpn(d);
  endtask

  task automatic step_control(input int ctrl, input logic down);
    int b;
    int lvl;
    int stp;
    int knob_no;
    if (ctrl < 0) return;
    if (ctrl >= NUM_KNOBS) begin
      b = ctrl - NUM_KNOBS;
      if (b < NUM_FADERS) fine_sel[b] = !down;
      return;
    end
    b = (ctrl >= NUM_FADERS) ? ctrl - NUM_FADERS : ctrl;
    stp = int'(coarse_st);
    if (b < NUM_FADERS && fine_sel[b]) stp = int'(fine_st);
    lvl = int'(knob_lvl[ctrl]);
    if (down) begin
      lvl = lvl - stp;
      if (lvl < 0) lvl = 0;
    end else begin
      lvl = lvl + stp;
      if (lvl > 127) lvl = 127;
    end
    knob_lvl[ctrl] = lvl[6:0];
    knob_no = ctrl + 1;
    put(1'b1, ST_CC_BASE | {4'h0, knob_chan}, knob_no[7:0], lvl[7:0]);
  endtask

  task automatic digest_software();
    if (num_hi[0] == NH_GROUP && num_lo[0] == NL_MASTER)
      move_fader(0, NUM_FADERS - 1);
    else if (num_hi[0] == NH_FADER)
      move_fader(0, int'(num_lo[0]) - int'(NL_FADER0));
    else
      relay_nrpn(0);
  endtask

  task automatic digest_surface();
    int   nl;
    logic down;
    nl = int'(num_lo[1]);
    down = (ent_hi[1] != 7'd0);
    case (num_hi[1])
      NH_KNOB:    step_control(nl - int'(NL_KNOB0), down);
      NH_KNOB_HI: step_control(NUM_FADERS + nl - int'(NL_KNOB_HI0), down);
      NH_BUTTON:  step_control(NUM_KNOBS + nl - int'(NL_BUTTON0), down);
      NH_GROUP: begin
        if (num_lo[1] >= NL_MASTER)
          move_fader(1, NUM_FADERS - 1);
        else
          step_control((nl - int'(NL_GROUP0)) * NUM_FADERS + NUM_FADERS - 1, down);
      end
      NH_FADER:   move_fader(1, nl - int'(NL_FADER0));
      default:    relay_nrpn(1);
    endcase
  endtask

  task automatic translate_msg(input logic d, input logic [7:0] st, a, b);
    run_msgs.delete();
    if (st != ST_CC16) begin
      put(d, st, a, b);
    end else begin
      case (a)
        CC_NRPN_MSB: num_hi[d] = b[6:0];
        CC_NRPN_LSB: num_lo[d] = b[6:0];
        CC_DATA_MSB: ent_hi[d] = b[6:0];
        CC_DATA_LSB: begin
          ent_lo[d] = b[6:0];
          if (d) digest_surface();
          else digest_software();
        end
        default: ;
      endcase
    end
    if (run_msgs.size() > 0) run_msgs[run_msgs.size() - 1].last = 1'b1;
    foreach (run_msgs[i]) pending_msgs.push_back(run_msgs[i]);
  endtask

  task automatic check_word(input midi_msg_t got);
    midi_msg_t want;
    if (pending_msgs.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%0t: unexpected word sw=%0d st=%02h a=%02h b=%02h last=%0d",
                 $time, got.to_sw, got.status, got.first, got.second, got.last);
      return;
    end
    want = pending_msgs.pop_front();
    if (got.to_sw !== want.to_sw || got.status !== want.status ||
        got.first !== want.first || got.second !== want.second ||
        got.last !== want.last) begin
      bad_count++;
      if (bad_count <= 10)
        $display({"%0t: word mismatch: expected sw=%0d st=%02h a=%02h b=%02h last=%0d,",
                  " got sw=%0d st=%02h a=%02h b=%02h last=%0d"},
                 $time, want.to_sw, want.status, want.first, want.second, want.last,
                 got.to_sw, got.status, got.first, got.second, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thr       = THRESHOLD_RST;
      fine_st   = FINE_RST;
      coarse_st = COARSE_RST;
      knob_chan = CHANNEL_RST;
      for (int i = 0; i < 2; i++) begin
        num_hi[i] = '0;
        num_lo[i] = '0;
        ent_hi[i] = '0;
        ent_lo[i] = '0;
      end
      for (int i = 0; i < NUM_FADERS; i++) begin
        fader_pos[i] = int'(FADER_RST);
        fine_sel[i]  = 1'b0;
      end
      for (int i = 0; i < NUM_KNOBS; i++) knob_lvl[i] = '0;
      pending_msgs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLOSE_THRESHOLD: thr       = cfg_wdata;
          CFG_FINE_STEP:       fine_st   = cfg_wdata[6:0];
          CFG_COARSE_STEP:     coarse_st = cfg_wdata[6:0];
          CFG_KNOB_CHANNEL:    knob_chan = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready)
        check_word({out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tlast});
      if (in_tvalid && in_tready)
        translate_msg(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
    end
    mismatches <= bad_count;
    waiting    <= pending_msgs.size();
  end

endmodule

[verif/tb_midi_nrpn_control_translator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_midi_nrpn_control_translator
// Stimulus and verdict for the NRPN control translator.
// A directed opening covers pass-through, stray channel-16 controllers,
// forwarding, fader suppression, knob clamping and buttons. Random NRPN
// sequences and noise follow under several register settings, with random
// gaps on both sides and one long output stall.
// ---------------------------------------------------------------------------
module tb_midi_nrpn_control_translator;
  import mnct_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // status_byte, first_data, second_data
  logic        in_tuser;   // from_surface
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // out_status, out_first, out_second
  logic        out_tuser;  // to_software
  logic        out_tlast;  // last_of_run
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [13:0] cfg_wdata;

  int mismatches;
  int waiting;
  int max_gap = 5;
  bit hold_req = 1'b0;

  midi_nrpn_control_translator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  nrpn_translation_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .waiting(waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_side
    int stall;
    out_tready = 1'b0;
    repeat (3) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = $urandom_range(0, max_gap);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // valid stays up after a word is taken unless the next draw is a gap
  task automatic send_msg(input logic d, input logic [7:0] st, a, b);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= d;
    in_tdata  <= {b, a, st};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_nrpn(input logic d, input logic [6:0] nh, nl, eh, el, input int skip);
    if (skip != 0) send_msg(d, ST_CC16, CC_NRPN_MSB, {1'($urandom_range(0, 1)), nh});
    if (skip != 1) send_msg(d, ST_CC16, CC_NRPN_LSB, {1'($urandom_range(0, 1)), nl});
    if (skip != 2) send_msg(d, ST_CC16, CC_DATA_MSB, {1'($urandom_range(0, 1)), eh});
    send_msg(d, ST_CC16, CC_DATA_LSB, {1'($urandom_range(0, 1)), el});
  endtask

  task automatic drain_quiet();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_traffic(input int count);
    int         sent;
    logic       d;
    logic [6:0] nh;
    logic [6:0] nl;
    logic [6:0] eh;
    logic [7:0] st;
    int         skip;
    sent = 0;
    while (sent < count) begin
      d = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        7, 8: begin
          st = 8'($urandom_range(0, 255));
          send_msg(d, st, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          sent++;
        end
        9: begin
          send_msg(d, ST_CC16, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          sent++;
        end
        default: begin
          case ($urandom_range(0, 5))
            0: begin nh = NH_KNOB;    nl = NL_KNOB0 + 7'($urandom_range(0, 11)); end
            1: begin nh = NH_KNOB_HI; nl = NL_KNOB_HI0 + 7'($urandom_range(0, 10)); end
            2: begin nh = NH_BUTTON;  nl = NL_BUTTON0 + 7'($urandom_range(0, 10)); end
            3: begin nh = NH_FADER;   nl = NL_FADER0 + 7'($urandom_range(0, 10)); end
            4: begin nh = NH_GROUP;   nl = 7'h12 + 7'($urandom_range(0, 7)); end
            default: begin
              nh = 7'($urandom_range(0, 127));
              nl = 7'($urandom_range(0, 127));
            end
          endcase
          if ($urandom_range(0, 4) == 0) nl = 7'($urandom_range(0, 127));
          eh = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(0, 127));
          skip = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 3;
          send_nrpn(d, nh, nl, eh, 7'($urandom_range(0, 127)), skip);
          sent += 4;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_CLOSE_THRESHOLD;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pass-through extremes, then a stray channel-16 controller
    send_msg(1'b0, 8'h00, 8'h00, 8'h00);
    send_msg(1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_msg(1'b1, 8'hBE, CC_NRPN_MSB, 8'h05);
    send_msg(1'b0, ST_CC16, 8'h07, 8'h40);
    // surface knob turned down from zero: clamps at the bottom
    send_nrpn(1'b1, NH_KNOB, NL_KNOB0, 7'h01, 7'h00, 3);
    // surface button released, selecting the fine step
    send_nrpn(1'b1, NH_BUTTON, NL_BUTTON0, 7'h00, 7'h00, 3);
    // software master fader, far from its reset value: forwarded
    send_nrpn(1'b0, NH_GROUP, NL_MASTER, 7'h7F, 7'h7F, 3);
    // other software number: forwarded as four words
    send_msg(1'b0, ST_CC16, CC_NRPN_MSB, 8'h00);
    send_msg(1'b0, ST_CC16, CC_DATA_LSB, 8'h80);
    // surface fader index beyond the store: silent
    send_msg(1'b1, ST_CC16, CC_NRPN_MSB, {1'b0, NH_FADER});
    send_msg(1'b1, ST_CC16, CC_NRPN_LSB, 8'h7F);
    send_msg(1'b1, ST_CC16, CC_DATA_LSB, 8'h12);
    // master fader again at the same value: suppressed
    send_msg(1'b0, ST_CC16, CC_NRPN_MSB, {1'b0, NH_GROUP});
    send_msg(1'b0, ST_CC16, CC_DATA_LSB, 8'h7F);
    drain_quiet();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: begin
          write_reg(CFG_CLOSE_THRESHOLD, 14'd0);
          write_reg(CFG_FINE_STEP, 14'd127);
          write_reg(CFG_COARSE_STEP, 14'd0);
          write_reg(CFG_KNOB_CHANNEL, 14'd15);
        end
        2: begin
          write_reg(CFG_CLOSE_THRESHOLD, 14'd16383);
          write_reg(CFG_FINE_STEP, 14'd0);
          write_reg(CFG_COARSE_STEP, 14'd127);
          write_reg(CFG_KNOB_CHANNEL, 14'($urandom_range(0, 15)));
        end
        3: begin
          write_reg(CFG_CLOSE_THRESHOLD, 14'($urandom_range(0, 2000)));
          write_reg(CFG_FINE_STEP, 14'($urandom_range(0, 127)));
          write_reg(CFG_COARSE_STEP, 14'($urandom_range(0, 127)));
          write_reg(CFG_KNOB_CHANNEL, 14'($urandom_range(0, 15)));
        end
        default: ;
      endcase
      max_gap = 0;
      random_traffic(20);
      max_gap = 5;
      random_traffic(50);
      if (phase == 1) begin
        // long output stall while forwarded numbers keep arriving
        hold_req = 1'b1;
        repeat (12)
          send_nrpn(1'b1, 7'h40, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 127)), 3);
      end
      drain_quiet();
    end

    repeat (16) @(negedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
src/mnct_pkg.sv
src/mnct_digest.sv
src/mnct_obuf.sv
src/midi_nrpn_control_translator.sv
verif/nrpn_translation_checker.sv
verif/tb_midi_nrpn_control_translator.sv
